/* src/ldq_pkg.sv */
// ldq_pkg: shared types and opcode constants for the linked deque block
// no dependencies
`timescale 1ns / 1ps

package ldq_pkg;

    localparam int OP_BITS = 4;

    typedef enum logic [3:0] {
        OP_INS_HEAD   = 4'd0,
        OP_INS_TAIL   = 4'd1,
        OP_POP_HEAD   = 4'd2,
        OP_POP_TAIL   = 4'd3,
        OP_PEEK_HEAD  = 4'd4,
        OP_PEEK_TAIL  = 4'd5,
        OP_CUR_HEAD   = 4'd6,
        OP_CUR_TAIL   = 4'd7,
        OP_FORWARD    = 4'd8,
        OP_BACKWARD   = 4'd9,
        OP_CUR_PEEK   = 4'd10,
        OP_INS_AFTER  = 4'd11,
        OP_INS_BEFORE = 4'd12,
        OP_CUR_DELETE = 4'd13,
        OP_RSVD_14    = 4'd14,
        OP_RSVD_15    = 4'd15
    } opcode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_BITS-1:0] opcode;
        logic [31:0]        item_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_value;
        logic [1:0]  status;
        logic [8:0]  length;
        logic        cursor_at_first;
        logic        cursor_at_last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_FIX,
        S_OUT
    } ldq_state_t;

endpackage

/* src/ldq_ram.sv */
// ldq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module ldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/linked_deque_with_cursor.sv */
// linked_deque_with_cursor: top level of the doubly linked list with cursor
// depends on ldq_pkg and ldq_ram
`timescale 1ns / 1ps

// Doubly linked list kept in a pool of NODE_COUNT nodes, with one cursor.
// One transaction in gives exactly one transaction out. Payload, next and
// prev links and the free stack each live in a RAM with a registered read;
// head, tail, cursor and the counts are flops. From accept to result valid
// an insert steps through reading the target node and the free stack top,
// writing the new node's own links, writing the neighbor links and loading
// the result; a pop or delete reads the node, unlinks it and pushes it on
// the free stack, then loads the result; peeks, cursor moves, pool-full
// inserts and refused operations read and then load the result. The block
// returns to idle as the result register loads and accepts the next
// transaction there; it takes no new item while one is in progress. A new item
// can be taken while the previous result still waits for ready; that item
// then waits in its result step until the output register is drained.
// No clearing pass is needed after reset: unused nodes are allocated from a
// fresh count. Payload values above 32 bits are truncated on out_value.
module linked_deque_with_cursor #(
    parameter int NODE_COUNT = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldq_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ldq_pkg::out_item_t out_data
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PW = $clog2(NODE_COUNT + 1);
    localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

    // list state
    logic [PW-1:0] head_reg, tail_reg, cur_reg, count_reg, free_reg, fresh_reg;
    logic [PW-1:0] head_next, tail_next, cur_next, count_next, free_next, fresh_next;

    ldq_pkg::ldq_state_t state_reg, state_next;
    logic [3:0]            op_reg, op_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [PW-1:0]         n_reg, n_next;     // node operated on
    logic [PW-1:0]         p_reg, p_next;     // prev neighbor
    logic [PW-1:0]         q_reg, q_next;     // next neighbor
    logic [1:0]            st_reg, st_next;
    logic [31:0]           ov_reg, ov_next;
    logic                  outv_reg, outv_next;
    ldq_pkg::out_item_t    out_reg, out_next;

    // ram ports
    logic                  pay_we, nx_we, pv_we, fs_we;
    logic [AW-1:0]         pay_wa, nx_wa, pv_wa, fs_wa, pay_ra, nx_ra, pv_ra, fs_ra;
    logic [VALUE_BITS-1:0] pay_wd, pay_rd;
    logic [PW-1:0]         nx_wd, pv_wd, nx_rd, pv_rd;
    logic [AW-1:0]         fs_wd, fs_rd;

    ldq_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_COUNT)) u_pay (
        .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(pay_wd),
        .raddr(pay_ra), .rdata(pay_rd));
    ldq_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .raddr(nx_ra), .rdata(nx_rd));
    ldq_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .raddr(pv_ra), .rdata(pv_rd));
    ldq_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_free (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_ra), .rdata(fs_rd));

    // result slot free: output register empty or being drained
    logic out_free;
    assign out_free = !outv_reg || out_ready;
    assign in_ready = (state_reg == ldq_pkg::S_IDLE);
    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    logic [3:0] op_in;
    assign op_in = in_data.opcode;

    function automatic logic [AW-1:0] ax(input logic [PW-1:0] p);
        return p[AW-1:0];
    endfunction

    always_comb
    begin
        logic [PW-1:0] nn;
        logic          is_ins, cur_null;
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        st_next      = st_reg;
        ov_next      = ov_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        fresh_next   = fresh_reg;
        outv_next    = outv_reg && !out_ready;
        out_next     = out_reg;
        pay_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; fs_we = 1'b0;
        pay_wa = '0; nx_wa = '0; pv_wa = '0; fs_wa = '0;
        pay_wd = val_reg; nx_wd = NIL; pv_wd = NIL; fs_wd = '0;
        pay_ra = ax(cur_reg); nx_ra = ax(cur_reg); pv_ra = ax(cur_reg);
        fs_ra  = ax(free_reg - PW'(1));
        nn = NIL;
        is_ins = (op_reg == ldq_pkg::OP_INS_HEAD) || (op_reg == ldq_pkg::OP_INS_TAIL)
              || (op_reg == ldq_pkg::OP_INS_AFTER) || (op_reg == ldq_pkg::OP_INS_BEFORE);
        cur_null = (cur_reg == NIL);

        unique case (state_reg)
            ldq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op_in;
                    val_next     = VALUE_BITS'(in_data.item_value);
                    st_next      = ldq_pkg::ST_OK;
                    ov_next      = '0;
                    state_next   = ldq_pkg::S_READ;
                    // choose node whose links and payload are read
                    case (op_in)
                        ldq_pkg::OP_POP_HEAD, ldq_pkg::OP_PEEK_HEAD: n_next = head_reg;
                        ldq_pkg::OP_POP_TAIL, ldq_pkg::OP_PEEK_TAIL: n_next = tail_reg;
                        default: n_next = cur_reg;
                    endcase
                    pay_ra = ax(n_next);
                    nx_ra  = ax(n_next);
                    pv_ra  = ax(n_next);
                end
            end

            ldq_pkg::S_READ:
            begin
                // link data of n_reg available now; free stack top too
                state_next = ldq_pkg::S_EXEC;
                if (is_ins)
                begin
                    if (free_reg == '0 && fresh_reg == NIL)
                    begin
                        st_next = ldq_pkg::ST_FULL;
                        state_next = ldq_pkg::S_OUT;
                    end
                    else
                    begin
                        if (free_reg != '0)
                        begin
                            nn = PW'(fs_rd);
                            free_next = free_reg - PW'(1);
                        end
                        else
                        begin
                            nn = fresh_reg;
                            fresh_next = fresh_reg + PW'(1);
                        end
                        pay_we = 1'b1;
                        pay_wa = ax(nn);
                        n_next = nn;
                        // neighbors of the new node
                        case (op_reg)
                            ldq_pkg::OP_INS_HEAD:
                            begin
                                p_next = NIL; q_next = head_reg;
                            end
                            ldq_pkg::OP_INS_TAIL:
                            begin
                                p_next = tail_reg; q_next = NIL;
                            end
                            ldq_pkg::OP_INS_AFTER:
                            begin
                                if (cur_null)
                                begin
                                    p_next = tail_reg; q_next = NIL; cur_next = nn;
                                end
                                else
                                begin
                                    p_next = cur_reg; q_next = nx_rd;
                                    if (cur_reg == tail_reg) cur_next = nn;
                                end
                            end
                            default:
                            begin
                                if (cur_null)
                                begin
                                    p_next = NIL; q_next = head_reg; cur_next = nn;
                                end
                                else
                                begin
                                    p_next = pv_rd; q_next = cur_reg;
                                    if (cur_reg == head_reg) cur_next = nn;
                                end
                            end
                        endcase
                    end
                end
                else
                begin
                    p_next = pv_rd;
                    q_next = nx_rd;
                    case (op_reg)
                        ldq_pkg::OP_POP_HEAD, ldq_pkg::OP_POP_TAIL:
                        begin
                            if (n_reg == NIL)
                            begin
                                st_next = ldq_pkg::ST_NONE; state_next = ldq_pkg::S_OUT;
                            end
                            else
                            begin
                                ov_next = 32'(pay_rd);
                                if (cur_reg == n_reg) cur_next = NIL;
                            end
                        end
                        ldq_pkg::OP_PEEK_HEAD, ldq_pkg::OP_PEEK_TAIL,
                        ldq_pkg::OP_CUR_PEEK:
                        begin
                            if (n_reg == NIL) st_next = ldq_pkg::ST_NONE;
                            else ov_next = 32'(pay_rd);
                            state_next = ldq_pkg::S_OUT;
                        end
                        ldq_pkg::OP_CUR_HEAD, ldq_pkg::OP_CUR_TAIL:
                        begin
                            cur_next = (op_reg == ldq_pkg::OP_CUR_HEAD) ? head_reg
                                                                       : tail_reg;
                            if (cur_next == NIL) st_next = ldq_pkg::ST_NONE;
                            state_next = ldq_pkg::S_OUT;
                        end
                        ldq_pkg::OP_FORWARD, ldq_pkg::OP_BACKWARD:
                        begin
                            nn = (op_reg == ldq_pkg::OP_FORWARD) ? nx_rd : pv_rd;
                            if (cur_null || nn == NIL) st_next = ldq_pkg::ST_NONE;
                            else cur_next = nn;
                            state_next = ldq_pkg::S_OUT;
                        end
                        ldq_pkg::OP_CUR_DELETE:
                        begin
                            if (cur_null)
                            begin
                                st_next = ldq_pkg::ST_NONE; state_next = ldq_pkg::S_OUT;
                            end
                            else
                            begin
                                ov_next  = 32'(pay_rd);
                                cur_next = (nx_rd != NIL) ? nx_rd : pv_rd;
                            end
                        end
                        default:
                        begin
                            st_next = ldq_pkg::ST_NONE; state_next = ldq_pkg::S_OUT;
                        end
                    endcase
                end
            end

            ldq_pkg::S_EXEC:
            begin
                // node's own links (insert), or unlink from both neighbors and push the free stack (remove)
                state_next = ldq_pkg::S_FIX;
                if (is_ins)
                begin
                    nx_we = 1'b1; nx_wa = ax(n_reg); nx_wd = q_reg;
                    pv_we = 1'b1; pv_wa = ax(n_reg); pv_wd = p_reg;
                end
                else
                begin
                    if (p_reg != NIL)
                    begin
                        nx_we = 1'b1; nx_wa = ax(p_reg); nx_wd = q_reg;
                    end
                    else head_next = q_reg;
                    if (q_reg != NIL)
                    begin
                        pv_we = 1'b1; pv_wa = ax(q_reg); pv_wd = p_reg;
                    end
                    else tail_next = p_reg;
                    if (free_reg != NIL)
                    begin
                        fs_we = 1'b1; fs_wa = ax(free_reg); fs_wd = ax(n_reg);
                        free_next = free_reg + PW'(1);
                    end
                    count_next = count_reg - PW'(1);
                    state_next = ldq_pkg::S_OUT;
                end
            end

            ldq_pkg::S_FIX:
            begin
                // neighbors point at the inserted node
                if (p_reg != NIL)
                begin
                    nx_we = 1'b1; nx_wa = ax(p_reg); nx_wd = n_reg;
                end
                else head_next = n_reg;
                if (q_reg != NIL)
                begin
                    pv_we = 1'b1; pv_wa = ax(q_reg); pv_wd = n_reg;
                end
                else tail_next = n_reg;
                count_next = count_reg + PW'(1);
                state_next = ldq_pkg::S_OUT;
            end

            ldq_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    outv_next = 1'b1;
                    out_next.out_value = ov_reg;
                    out_next.status    = st_reg;
                    out_next.length    = 9'(count_reg);
                    out_next.cursor_at_first = (count_reg == '0)
                        || (cur_reg != NIL && cur_reg == head_reg);
                    out_next.cursor_at_last  = (count_reg == '0)
                        || (cur_reg != NIL && cur_reg == tail_reg);
                    state_next = ldq_pkg::S_IDLE;
                end
            end

            default: state_next = ldq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ldq_pkg::S_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cur_reg   <= NIL;
            count_reg <= '0;
            free_reg  <= '0;
            fresh_reg <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        n_reg       <= n_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        st_reg      <= st_next;
        ov_reg      <= ov_next;
        out_reg     <= out_next;
    end

    // list length never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= PW'(NODE_COUNT))
        else $error("length beyond pool");
    // head and tail are null together exactly when the list is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == NIL && tail_reg == NIL))
        else $error("head/tail out of step with length");
    // result only produced from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(outv_reg) |-> $past(state_reg) == ldq_pkg::S_OUT)
        else $error("result without operation");

endmodule
